### src/tfn_pkg.sv
`timescale 1ns / 1ps
package tfn_pkg;
    localparam int COORD_WIDTH  = 24;
    localparam int NORMAL_WIDTH = 16;

    // Operand and intermediate widths
    localparam int EDGE_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int M_W     = 30;
    localparam int MAG_W   = (CROSS_W > M_W) ? CROSS_W : M_W + 1;
    localparam int SHIFT_W = $clog2(MAG_W - M_W + 1);
    localparam int SQ_W    = 2 * M_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int XW      = ROOT_W + 1 + NORMAL_WIDTH;

    // Register stages: front end, squares and sum, root digits, quotient bits, output
    localparam int LATENCY = 5 + 2 + ROOT_W + NORMAL_WIDTH + 1;

    typedef struct packed {
        logic [2:0][M_W-1:0] m;
        logic [2:0]          neg;
        logic                degen;
    } tfn_side_t;
endpackage

### src/triangle_face_normal_top.sv
`timescale 1ns / 1ps
// Triangle face normal: each start transfer comes out as one result on done.
// Throughput is one triangle per cycle; busy stays low, start may be high every cycle.
// Most of the depth lies in the 31 root-digit stages and the 16 quotient-bit stages.
// done pulses for one cycle with the result; the receiver cannot stall it.
// rst_n clears all valid bits asynchronously; items in flight are dropped.
module triangle_face_normal_top
    import tfn_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_WIDTH-1:0]  a_x,
    input  logic signed [COORD_WIDTH-1:0]  a_y,
    input  logic signed [COORD_WIDTH-1:0]  a_z,
    input  logic signed [COORD_WIDTH-1:0]  b_x,
    input  logic signed [COORD_WIDTH-1:0]  b_y,
    input  logic signed [COORD_WIDTH-1:0]  b_z,
    input  logic signed [COORD_WIDTH-1:0]  c_x,
    input  logic signed [COORD_WIDTH-1:0]  c_y,
    input  logic signed [COORD_WIDTH-1:0]  c_z,
    output logic                           done,
    output logic signed [NORMAL_WIDTH-1:0] normal_x,
    output logic signed [NORMAL_WIDTH-1:0] normal_y,
    output logic signed [NORMAL_WIDTH-1:0] normal_z,
    output logic                           degenerate
);
    logic                         front_vld;
    tfn_side_t                    front_side;
    logic                         sqrt_vld;
    logic [ROOT_W-1:0]            sqrt_root;
    tfn_side_t                    sqrt_side;
    logic [2:0][NORMAL_WIDTH-1:0] normal;

    // The pipeline never stalls, so a start transfer is taken in every cycle
    assign busy = 1'b0;

    // Edges, cross product, magnitudes and the normalizing shift
    tfn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (start && !busy),
        .a        ({a_z, a_y, a_x}),
        .b        ({b_z, b_y, b_x}),
        .c        ({c_z, c_y, c_x}),
        .out_vld  (front_vld),
        .out_side (front_side)
    );

    // Squared length and its integer square root
    tfn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (front_vld),
        .in_side  (front_side),
        .out_vld  (sqrt_vld),
        .out_root (sqrt_root),
        .out_side (sqrt_side)
    );

    // Per-component rounded division by the length, then saturation
    tfn_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_vld     (sqrt_vld),
        .in_root    (sqrt_root),
        .in_side    (sqrt_side),
        .out_vld    (done),
        .out_normal (normal),
        .out_degen  (degenerate)
    );

    assign normal_x = $signed(normal[0]);
    assign normal_y = $signed(normal[1]);
    assign normal_z = $signed(normal[2]);

    // Every transfer in comes out as a result on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after fixed latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching start transfer");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
        else $error("degenerate result with nonzero normal");
endmodule

### src/tfn_front.sv
`timescale 1ns / 1ps
module tfn_front
    import tfn_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_vld,
    input  logic [2:0][COORD_WIDTH-1:0] a,
    input  logic [2:0][COORD_WIDTH-1:0] b,
    input  logic [2:0][COORD_WIDTH-1:0] c,
    output logic                        out_vld,
    output tfn_side_t                   out_side
);
    logic [4:0]               vld_reg;
    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] e2_reg [3];
    logic signed [PROD_W-1:0] p_reg [6];
    logic signed [CROSS_W-1:0] x_reg [3];
    logic [MAG_W-1:0]         mag_reg [3];
    logic [2:0]               neg_reg;
    logic                     degen_reg;
    tfn_side_t                side_reg;

    logic [CROSS_W-1:0]       mag_abs [3];
    logic [MAG_W-1:0]         or_v;
    logic [SHIFT_W-1:0]       shamt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[3:0], in_vld};
    end

    // Edges, products, cross product
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1_reg[k] <= $signed({c[k][COORD_WIDTH-1], c[k]})
                       - $signed({b[k][COORD_WIDTH-1], b[k]});
            e2_reg[k] <= $signed({a[k][COORD_WIDTH-1], a[k]})
                       - $signed({b[k][COORD_WIDTH-1], b[k]});
        end
        p_reg[0] <= e1_reg[1] * e2_reg[2];
        p_reg[1] <= e1_reg[2] * e2_reg[1];
        p_reg[2] <= e1_reg[2] * e2_reg[0];
        p_reg[3] <= e1_reg[0] * e2_reg[2];
        p_reg[4] <= e1_reg[0] * e2_reg[1];
        p_reg[5] <= e1_reg[1] * e2_reg[0];
        for (int k = 0; k < 3; k++)
            x_reg[k] <= CROSS_W'(p_reg[2*k]) - CROSS_W'(p_reg[2*k+1]);
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            mag_abs[k] = x_reg[k][CROSS_W-1] ? (~x_reg[k] + 1'b1) : x_reg[k];
    end

    // Magnitudes, signs and degenerate flag
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_reg[k] <= MAG_W'(mag_abs[k]);
            neg_reg[k] <= x_reg[k][CROSS_W-1];
        end
        degen_reg <= (x_reg[0] == '0) && (x_reg[1] == '0) && (x_reg[2] == '0);
    end

    // The OR of the magnitudes has the same bit length as their maximum
    always_comb
    begin
        or_v  = mag_reg[0] | mag_reg[1] | mag_reg[2];
        shamt = '0;
        for (int k = M_W; k < MAG_W; k++)
            if (or_v[k])
                shamt = SHIFT_W'(k - M_W + 1);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            side_reg.m[k] <= M_W'(mag_reg[k] >> shamt);
        side_reg.neg   <= neg_reg;
        side_reg.degen <= degen_reg;
    end

    assign out_vld  = vld_reg[4];
    assign out_side = side_reg;
endmodule

### src/tfn_sqrt.sv
`timescale 1ns / 1ps
module tfn_sqrt
    import tfn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  tfn_side_t         in_side,
    output logic              out_vld,
    output logic [ROOT_W-1:0] out_root,
    output tfn_side_t         out_side
);
    logic [SQ_W-1:0]   sq_reg [3];
    logic [SUM_W-1:0]  sum_reg;
    tfn_side_t         sa_reg, sb_reg;
    logic [1:0]        pre_vld_reg;

    logic [SUM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    tfn_side_t         side_reg [ROOT_W];
    logic [ROOT_W-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= '0;
            vld_reg     <= '0;
        end
        else
        begin
            pre_vld_reg <= {pre_vld_reg[0], in_vld};
            vld_reg     <= {vld_reg[ROOT_W-2:0], pre_vld_reg[1]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            sq_reg[k] <= in_side.m[k] * in_side.m[k];
        sa_reg  <= in_side;
        sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        sb_reg  <= sa_reg;
    end

    // One root bit per stage, most significant first
    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_digit
        localparam int BIT = ROOT_W - 1 - g;
        logic [SUM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        tfn_side_t         side_in;
        logic [SUM_W-1:0]  trial;

        if (g == 0)
        begin : g_first
            assign rem_in  = sum_reg;
            assign root_in = '0;
            assign side_in = sb_reg;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        assign trial = (SUM_W'(root_in) << (BIT + 1)) | (SUM_W'(1) << (2 * BIT));

        always_ff @(posedge clk)
        begin
            if (rem_in >= trial)
            begin
                rem_reg[g]  <= rem_in - trial;
                root_reg[g] <= root_in | (ROOT_W'(1) << BIT);
            end
            else
            begin
                rem_reg[g]  <= rem_in;
                root_reg[g] <= root_in;
            end
            side_reg[g] <= side_in;
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign out_root = root_reg[ROOT_W-1];
    assign out_side = side_reg[ROOT_W-1];
endmodule

### src/tfn_div.sv
`timescale 1ns / 1ps
module tfn_div
    import tfn_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    input  logic [ROOT_W-1:0]             in_root,
    input  tfn_side_t                     in_side,
    output logic                          out_vld,
    output logic [2:0][NORMAL_WIDTH-1:0]  out_normal,
    output logic                          out_degen
);
    localparam logic [NORMAL_WIDTH-1:0] ONE = NORMAL_WIDTH'(1) << (NORMAL_WIDTH - 1);

    logic [2:0][XW-1:0]           r_reg   [NORMAL_WIDTH];
    logic [2:0][NORMAL_WIDTH-1:0] q_reg   [NORMAL_WIDTH];
    logic [XW-1:0]                d_reg   [NORMAL_WIDTH];
    logic [2:0]                   neg_reg [NORMAL_WIDTH];
    logic                         dg_reg  [NORMAL_WIDTH];
    logic [NORMAL_WIDTH-1:0]      vld_reg;
    logic                         done_reg;
    logic [2:0][NORMAL_WIDTH-1:0] normal_reg;
    logic                         degen_reg;

    logic [2:0][NORMAL_WIDTH-1:0] normal_next;
    logic [NORMAL_WIDTH-1:0]      qs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[NORMAL_WIDTH-2:0], in_vld};
            done_reg <= vld_reg[NORMAL_WIDTH-1];
        end
    end

    // Restoring division, one quotient bit per stage for all three lanes
    for (genvar g = 0; g < NORMAL_WIDTH; g++)
    begin : g_qbit
        localparam int BIT = NORMAL_WIDTH - 1 - g;
        logic [2:0][XW-1:0]           r_in;
        logic [2:0][NORMAL_WIDTH-1:0] q_in;
        logic [XW-1:0]                d_in;
        logic [2:0]                   neg_in;
        logic                         dg_in;
        logic [XW-1:0]                dsh;

        if (g == 0)
        begin : g_first
            always_comb
            begin
                for (int k = 0; k < 3; k++)
                    r_in[k] = (XW'(in_side.m[k]) << NORMAL_WIDTH) + XW'(in_root);
            end
            assign q_in   = '0;
            assign d_in   = XW'({in_root, 1'b0});
            assign neg_in = in_side.neg;
            assign dg_in  = in_side.degen;
        end
        else
        begin : g_next
            assign r_in   = r_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign d_in   = d_reg[g-1];
            assign neg_in = neg_reg[g-1];
            assign dg_in  = dg_reg[g-1];
        end

        assign dsh = d_in << BIT;

        always_ff @(posedge clk)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (r_in[k] >= dsh)
                begin
                    r_reg[g][k] <= r_in[k] - dsh;
                    q_reg[g][k] <= q_in[k] | (NORMAL_WIDTH'(1) << BIT);
                end
                else
                begin
                    r_reg[g][k] <= r_in[k];
                    q_reg[g][k] <= q_in[k];
                end
            end
            d_reg[g]   <= d_in;
            neg_reg[g] <= neg_in;
            dg_reg[g]  <= dg_in;
        end
    end

    // Saturate, apply sign and zero the degenerate results
    always_comb
    begin
        normal_next = '0;
        qs          = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (neg_reg[NORMAL_WIDTH-1][k])
            begin
                qs = (q_reg[NORMAL_WIDTH-1][k] > ONE) ? ONE : q_reg[NORMAL_WIDTH-1][k];
                normal_next[k] = NORMAL_WIDTH'(0) - qs;
            end
            else
            begin
                qs = (q_reg[NORMAL_WIDTH-1][k] > ONE - 1'b1) ? ONE - 1'b1
                   : q_reg[NORMAL_WIDTH-1][k];
                normal_next[k] = qs;
            end
            if (dg_reg[NORMAL_WIDTH-1])
                normal_next[k] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        normal_reg <= normal_next;
        degen_reg  <= dg_reg[NORMAL_WIDTH-1];
    end

    assign out_vld    = done_reg;
    assign out_normal = normal_reg;
    assign out_degen  = degen_reg;
endmodule

### tb/tfn_normal_checker.sv
`timescale 1ns / 1ps
module tfn_normal_checker
    import tfn_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic signed [COORD_WIDTH-1:0]  a_x,
    input  logic signed [COORD_WIDTH-1:0]  a_y,
    input  logic signed [COORD_WIDTH-1:0]  a_z,
    input  logic signed [COORD_WIDTH-1:0]  b_x,
    input  logic signed [COORD_WIDTH-1:0]  b_y,
    input  logic signed [COORD_WIDTH-1:0]  b_z,
    input  logic signed [COORD_WIDTH-1:0]  c_x,
    input  logic signed [COORD_WIDTH-1:0]  c_y,
    input  logic signed [COORD_WIDTH-1:0]  c_z,
    input  logic                           done,
    input  logic signed [NORMAL_WIDTH-1:0] normal_x,
    input  logic signed [NORMAL_WIDTH-1:0] normal_y,
    input  logic signed [NORMAL_WIDTH-1:0] normal_z,
    input  logic                           degenerate,
    output int                             fail_count,
    output int                             pending
);
    typedef struct packed {
        logic [NORMAL_WIDTH-1:0] nx;
        logic [NORMAL_WIDTH-1:0] ny;
        logic [NORMAL_WIDTH-1:0] nz;
        logic                    degen;
    } face_normal_t;

    face_normal_t normal_q[$];

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [NORMAL_WIDTH-1:0] unit_component(
        input logic [63:0] m, input logic neg, input logic [63:0] len);
        logic [63:0] one;
        logic [63:0] q;
        one = 64'd1 << (NORMAL_WIDTH - 1);
        q = (2 * m * one + len) / (2 * len);
        if (neg)
        begin
            if (q > one) q = one;
            q = -q;
        end
        else if (q > one - 1)
            q = one - 1;
        return q[NORMAL_WIDTH-1:0];
    endfunction

    function automatic face_normal_t face_normal(
        input longint ax, input longint ay, input longint az,
        input longint bx, input longint by, input longint bz,
        input longint cx, input longint cy, input longint cz);
        face_normal_t r;
        longint e1[3];
        longint e2[3];
        longint xv[3];
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] len;
        int sh;
        e1[0] = cx - bx; e1[1] = cy - by; e1[2] = cz - bz;
        e2[0] = ax - bx; e2[1] = ay - by; e2[2] = az - bz;
        xv[0] = e1[1] * e2[2] - e1[2] * e2[1];
        xv[1] = e1[2] * e2[0] - e1[0] * e2[2];
        xv[2] = e1[0] * e2[1] - e1[1] * e2[0];
        r = '0;
        if (xv[0] == 0 && xv[1] == 0 && xv[2] == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (xv[i] < 0) ? -xv[i] : xv[i];
            if (m[i] > mx) mx = m[i];
        end
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 30)) sh++;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = m[i] >> sh;
            sum = sum + m[i] * m[i];
        end
        len = isqrt64(sum);
        if (len == 0) len = 1;
        r.nx = unit_component(m[0], xv[0] < 0, len);
        r.ny = unit_component(m[1], xv[1] < 0, len);
        r.nz = unit_component(m[2], xv[2] < 0, len);
        return r;
    endfunction

    assign pending = normal_q.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        face_normal_t want;
        if (rst_n)
        begin
            if (start && !busy)
                normal_q.push_back(face_normal(a_x, a_y, a_z, b_x, b_y, b_z,
                                               c_x, c_y, c_z));
            if (done)
            begin
                if (normal_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: %0d %0d %0d deg=%0b",
                                 normal_x, normal_y, normal_z, degenerate);
                end
                else
                begin
                    want = normal_q.pop_front();
                    if (want.nx !== normal_x || want.ny !== normal_y ||
                        want.nz !== normal_z || want.degen !== degenerate)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp %0d %0d %0d deg=%0b got %0d %0d %0d deg=%0b",
                                     $signed(want.nx), $signed(want.ny), $signed(want.nz),
                                     want.degen, normal_x, normal_y, normal_z, degenerate);
                    end
                end
            end
        end
    end
endmodule

### tb/tb_triangle_face_normal_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the face normal block. The checker beside the
// block predicts every transfer and counts mismatches.
module tb_triangle_face_normal_top;
    import tfn_pkg::*;

    localparam int WATCHDOG = 2000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic done;
    logic signed [NORMAL_WIDTH-1:0] normal_x, normal_y, normal_z;
    logic degenerate;
    int fail_count;
    int pending;
    int idle_cycles;

    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    triangle_face_normal_top dut (.*);

    tfn_normal_checker checker_i (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Count cycles with no transfer in or out; stop a hung run.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Hold one triangle on the ports until it transfers, then drop start
    // unless the next triangle follows with no gap.
    task automatic send_triangle(input logic signed [COORD_WIDTH-1:0] v[9],
                                 input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        a_x <= v[0]; a_y <= v[1]; a_z <= v[2];
        b_x <= v[3]; b_y <= v[4]; b_z <= v[5];
        c_x <= v[6]; c_y <= v[7]; c_z <= v[8];
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord(input int mode);
        case (mode)
            0: return COORD_WIDTH'($urandom);
            1: return COORD_WIDTH'($signed($urandom_range(0, 64)) - 32);
            2: return ($urandom_range(0, 1)) ? CMAX : CMIN;
            default: return COORD_WIDTH'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    initial
    begin
        logic signed [COORD_WIDTH-1:0] v[9];
        int gap;
        int mode;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        idle_cycles = 0;
        {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unit axes, degenerate cases, extreme coordinates.
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                      send_triangle(v, 0);
        v = '{0, 4096, 0, 0, 0, 0, 4096, 0, 0};                send_triangle(v, 0);
        v = '{4096, 0, 0, 0, 0, 0, 0, 4096, 0};                send_triangle(v, 1);
        v = '{0, 0, 4096, 0, 0, 0, 0, 4096, 0};                send_triangle(v, 0);
        v = '{0, 4096, 0, 0, 0, 0, 0, 0, 4096};                send_triangle(v, 0);
        v = '{1, 1, 1, 2, 2, 2, 3, 3, 3};                      send_triangle(v, 2);
        v = '{5, 5, 5, 5, 5, 5, 9, 1, 4};                      send_triangle(v, 0);
        v = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX}; send_triangle(v, 0);
        v = '{CMIN, 0, 0, CMAX, CMAX, 0, 0, CMIN, CMAX};       send_triangle(v, 0);
        v = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX}; send_triangle(v, 3);
        v = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN}; send_triangle(v, 0);
        v = '{CMAX, 0, 0, 0, CMAX, 0, 0, 0, CMAX};             send_triangle(v, 0);
        v = '{CMIN, 0, 0, 0, CMIN, 0, 0, 0, CMIN};             send_triangle(v, 0);
        v = '{1, 0, 0, 0, 0, 0, 0, 1, 0};                      send_triangle(v, 0);
        v = '{-1, 0, 0, 0, 0, 0, 0, -1, 0};                    send_triangle(v, 0);
        v = '{3, 0, 0, 0, 0, 0, 0, 0, 7};                      send_triangle(v, 0);
        v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};             send_triangle(v, 0);

        // Random: half full-range, plus small, extreme and medium-range mixes;
        // alternate bursts without gaps with stretches of random gaps.
        for (int n = 0; n < 850; n++)
        begin
            mode = $urandom_range(0, 9);
            for (int k = 0; k < 9; k++)
                v[k] = rand_coord(mode < 5 ? 0 : (mode < 7 ? 1 : (mode < 8 ? 2 : 3)));
            // An occasional collinear triangle hits the degenerate path.
            if ($urandom_range(0, 19) == 0)
                for (int k = 0; k < 3; k++)
                    v[6 + k] = COORD_WIDTH'(v[3 + k] + 2 * (v[k] - v[3 + k]));
            gap = ((n / 100) % 2 == 0) ? $urandom_range(0, 19) : 0;
            send_triangle(v, gap);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
